/* design/smt_pkg.sv */
// Shared widths, the token that moves down the cell chain, and count helpers.
package smt_pkg;

    localparam int TABLE_DEPTH       = 64;
    localparam int COUNT_BITS        = 32;
    localparam int VALUE_BITS        = 64;
    localparam int RESULT_COUNT_BITS = 32;

    typedef logic [VALUE_BITS-1:0]        value_t;
    typedef logic [COUNT_BITS-1:0]        count_t;
    typedef logic [RESULT_COUNT_BITS-1:0] result_count_t;

    localparam count_t COUNT_MAX = '1;
    localparam count_t COUNT_ONE = count_t'(1);

    // One column element on its way through the table cells.
    typedef struct packed {
        logic   valid;
        value_t value;
        logic   present;
        logic   last;
        logic   absorbed;
        count_t count;
    } tok_t;

    function automatic count_t sat_inc(input count_t c);
        sat_inc = (c == COUNT_MAX) ? c : c + COUNT_ONE;
    endfunction

    function automatic result_count_t clamp_count(input count_t c);
        logic [63:0] wide;
        wide = 64'(c);
        clamp_count = (wide > 64'h0000_0000_FFFF_FFFF) ? '1 : wide[RESULT_COUNT_BITS-1:0];
    endfunction

endpackage

/* design/smt_if.sv */
// Stream interfaces for column elements and mode results.
interface smt_in_if
    import smt_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t value;
    logic   is_present;
    logic   last_item;

    modport source (output valid, output value, output is_present, output last_item,
                    input ready);
    modport sink (input valid, input value, input is_present, input last_item,
                  output ready);
endinterface

interface smt_out_if
    import smt_pkg::*;
();
    logic          valid;
    logic          ready;
    value_t        mode_value;
    result_count_t mode_count;
    logic          any_present;
    logic          table_overflow;

    modport source (output valid, output mode_value, output mode_count,
                    output any_present, output table_overflow, input ready);
    modport sink (input valid, input mode_value, input mode_count,
                  input any_present, input table_overflow, output ready);
endinterface

/* design/smt_cell.sv */
// One table entry: matches or claims a passing element, then hands it on.
module smt_cell
    import smt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  tok_t tok_in,
    output tok_t tok_out
);

    logic   used_reg, used_next;
    value_t value_reg, value_next;
    count_t count_reg, count_next;
    tok_t   tok_reg, tok_next;
    logic   tok_valid_reg;

    logic   live;
    logic   hit;
    logic   claim;
    count_t inc;

    assign live  = tok_in.valid && tok_in.present && !tok_in.absorbed;
    assign hit   = live && used_reg && (value_reg == tok_in.value);
    assign claim = live && !used_reg;
    assign inc   = sat_inc(count_reg);

    always_comb
    begin
        value_next = value_reg;
        count_next = count_reg;
        used_next  = used_reg;
        tok_next   = tok_in;
        if (hit)
        begin
            count_next        = inc;
            tok_next.absorbed = 1'b1;
            tok_next.count    = inc;
        end
        else if (claim)
        begin
            value_next        = tok_in.value;
            count_next        = COUNT_ONE;
            used_next         = 1'b1;
            tok_next.absorbed = 1'b1;
            tok_next.count    = COUNT_ONE;
        end
        // The end of a column empties the entry once the element has used it.
        if (tok_in.valid && tok_in.last)
        begin
            used_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            used_reg      <= used_next;
            tok_valid_reg <= tok_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg <= value_next;
            count_reg <= count_next;
            tok_reg   <= tok_next;
        end
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

/* design/smt_tail.sv */
// End of the chain: keeps the best value and overflow, and holds the result.
module smt_tail
    import smt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  tok_t             tok_in,
    output logic             adv,
    smt_out_if.source        result
);

    value_t        best_value_reg, best_value_next;
    count_t        best_count_reg, best_count_next;
    logic          overflow_reg, overflow_next;
    logic          out_valid_reg, out_valid_next;
    value_t        out_value_reg;
    result_count_t out_count_reg;
    logic          out_any_reg;
    logic          out_ovf_reg;

    value_t cur_value;
    count_t cur_count;
    logic   cur_ovf;
    logic   take;

    // The whole chain moves only when the result register can take a new result.
    assign adv  = !out_valid_reg || result.ready;
    assign take = adv && tok_in.valid;

    always_comb
    begin
        cur_value = best_value_reg;
        cur_count = best_count_reg;
        cur_ovf   = overflow_reg;
        if (tok_in.valid && tok_in.present)
        begin
            if (!tok_in.absorbed)
            begin
                cur_ovf = 1'b1;
            end
            else if (tok_in.count > best_count_reg)
            begin
                cur_value = tok_in.value;
                cur_count = tok_in.count;
            end
        end
    end

    always_comb
    begin
        best_value_next = best_value_reg;
        best_count_next = best_count_reg;
        overflow_next   = overflow_reg;
        out_valid_next  = out_valid_reg;
        if (adv)
        begin
            out_valid_next = tok_in.valid && tok_in.last;
        end
        if (take)
        begin
            if (tok_in.last)
            begin
                best_value_next = '0;
                best_count_next = '0;
                overflow_next   = 1'b0;
            end
            else
            begin
                best_value_next = cur_value;
                best_count_next = cur_count;
                overflow_next   = cur_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_value_reg <= '0;
            best_count_reg <= '0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            best_value_reg <= best_value_next;
            best_count_reg <= best_count_next;
            overflow_reg   <= overflow_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && tok_in.last)
        begin
            out_value_reg <= cur_value;
            out_count_reg <= clamp_count(cur_count);
            out_any_reg   <= (cur_count != '0);
            out_ovf_reg   <= cur_ovf;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.mode_value     = out_value_reg;
    assign result.mode_count     = out_count_reg;
    assign result.any_present    = out_any_reg;
    assign result.table_overflow = out_ovf_reg;

endmodule

/* design/streaming_mode_tracker.sv */
// Streaming mode tracker: a chain of TABLE_DEPTH table cells feeding a best-value tail.
// Each column element enters the chain and moves one cell per cycle while the chain advances;
// the first cell holding its value counts it, otherwise the first free cell takes it, and the
// tail compares the resulting count against the best so far. One element is taken every
// cycle while the result register is free or being read; the result of a column is
// registered in the tail once its last element has passed every cell, and the cells empty
// themselves as that last element passes, so the next column can follow at once. A result
// still waiting to be taken holds the whole chain, and the element port with it.
module streaming_mode_tracker
    import smt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    smt_in_if.sink     elem,
    smt_out_if.source  result
);

    tok_t tok [TABLE_DEPTH+1];
    logic adv;

    assign elem.ready = adv;

    always_comb
    begin
        tok[0].valid    = elem.valid;
        tok[0].value    = elem.value;
        tok[0].present  = elem.is_present;
        tok[0].last     = elem.last_item;
        tok[0].absorbed = 1'b0;
        tok[0].count    = '0;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        smt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    smt_tail u_tail (
        .clk    (clk),
        .rst_n  (rst_n),
        .tok_in (tok[TABLE_DEPTH]),
        .adv    (adv),
        .result (result)
    );

endmodule

/* design/smt_checker.sv */
// Port-level checks for the streaming mode tracker, bound to its top level.
module smt_checker
    import smt_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          elem_ready,
    input logic          res_valid,
    input logic          res_ready,
    input value_t        res_value,
    input result_count_t res_count,
    input logic          res_any
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before transfer");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_value) && $stable(res_count))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_any |-> res_value == '0 && res_count == '0)
        else $error("empty column gave a nonzero mode");

    a_any_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_any |-> res_count != '0)
        else $error("mode count zero with a valid element");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !elem_ready |-> res_valid && !res_ready)
        else $error("element port stalled without a waiting result");

endmodule

bind streaming_mode_tracker smt_checker u_smt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .elem_ready (elem.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_value  (result.mode_value),
    .res_count  (result.mode_count),
    .res_any    (result.any_present)
);

/* sim/smt_mode_checker.sv */
// Checker for the mode tracker: predicts the mode of each column and compares every result.
module smt_mode_checker
    import smt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    smt_in_if           elem,
    smt_out_if          result,
    output int unsigned fail_count,
    output int unsigned pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef struct {
        value_t        mode_value;
        result_count_t mode_count;
        logic          any_present;
        logic          table_overflow;
    } mode_result_t;

    // Predicted table of distinct values for the column in progress.
    value_t tbl_value [TABLE_DEPTH];
    count_t tbl_count [TABLE_DEPTH];
    logic   tbl_used  [TABLE_DEPTH];
    value_t top_value;
    count_t top_count;
    logic   dropped;

    mode_result_t expected_modes [$];

    function automatic void clear_table();
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            tbl_used[k]  = 1'b0;
            tbl_value[k] = '0;
            tbl_count[k] = '0;
        end
        top_value = '0;
        top_count = '0;
        dropped   = 1'b0;
    endfunction

    function automatic void tally_element(input value_t v);
        int     hit;
        int     free_idx;
        count_t c;
        hit      = -1;
        free_idx = -1;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            if (tbl_used[k])
            begin
                if (hit < 0 && tbl_value[k] == v)
                    hit = k;
            end
            else if (free_idx < 0)
            begin
                free_idx = k;
            end
        end
        if (hit >= 0)
        begin
            c = tbl_count[hit];
            if (c != '1)
                c = c + count_t'(1);
            tbl_count[hit] = c;
        end
        else if (free_idx >= 0)
        begin
            tbl_used[free_idx]  = 1'b1;
            tbl_value[free_idx] = v;
            tbl_count[free_idx] = count_t'(1);
            c = count_t'(1);
        end
        else
        begin
            // Table full: the new value is lost, but the column is marked.
            dropped = 1'b1;
            return;
        end
        // Strictly greater, so on a tie the earlier value keeps the top spot.
        if (c > top_count)
        begin
            top_count = c;
            top_value = v;
        end
    endfunction

    function automatic mode_result_t column_mode();
        mode_result_t r;
        logic [63:0]  wide;
        wide             = 64'(top_count);
        r.mode_value     = top_value;
        r.mode_count     = (wide > 64'h0000_0000_FFFF_FFFF) ? '1
                                                           : wide[RESULT_COUNT_BITS-1:0];
        r.any_present    = (top_count != '0);
        r.table_overflow = dropped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mode_result_t want;
        if (!rst_n)
        begin
            clear_table();
            expected_modes.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_modes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] unexpected result: value %h count %0d any %b ovf %b",
                                 $realtime, result.mode_value, result.mode_count,
                                 result.any_present, result.table_overflow);
                end
                else
                begin
                    want = expected_modes.pop_front();
                    if (result.mode_value !== want.mode_value ||
                        result.mode_count !== want.mode_count ||
                        result.any_present !== want.any_present ||
                        result.table_overflow !== want.table_overflow)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("[%0t] mode mismatch: expected value %h count %0d",
                                     $realtime, want.mode_value, want.mode_count,
                                     " any %b ovf %b,", want.any_present,
                                     want.table_overflow,
                                     " got value %h count %0d any %b ovf %b",
                                     result.mode_value, result.mode_count,
                                     result.any_present, result.table_overflow);
                    end
                end
            end
            if (elem.valid && elem.ready)
            begin
                if (elem.is_present)
                    tally_element(elem.value);
                if (elem.last_item)
                begin
                    expected_modes.insert(expected_modes.size(), column_mode());
                    clear_table();
                end
            end
            pending_count = expected_modes.size();
        end
    end

endmodule

/* sim/tb_streaming_mode_tracker.sv */
// Testbench top for the streaming mode tracker: clock, reset, column stimulus and verdict.
module tb_streaming_mode_tracker
    import smt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESULT_LATENCY  = TABLE_DEPTH;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_ITEMS     = 480;

    typedef struct {
        value_t value;
        logic   present;
    } elem_t;

    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    smt_in_if  elem_bus ();
    smt_out_if result_bus ();

    streaming_mode_tracker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .elem   (elem_bus),
        .result (result_bus)
    );

    int unsigned fail_count;
    int unsigned pending_results;

    smt_mode_checker mode_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .elem          (elem_bus),
        .result        (result_bus),
        .fail_count    (fail_count),
        .pending_count (pending_results)
    );

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_cycles    = 0;
    int unsigned items_sent     = 0;
    int unsigned idle_cycles    = 0;
    elem_t       column [$];

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic value_t rand_value();
        return {$urandom, $urandom};
    endfunction

    // Appends one element to the column being built.
    function automatic void add_elem(input value_t v, input logic p);
        elem_t e;
        e.value   = v;
        e.present = p;
        column.insert(column.size(), e);
    endfunction

    // Offers one element from a falling edge and returns at the falling edge after its transfer.
    task automatic send_elem(input value_t v, input logic p, input logic l);
        while (chance(send_idle_pct))
        begin
            elem_bus.valid      <= 1'b0;
            elem_bus.value      <= rand_value();
            elem_bus.is_present <= 1'($urandom_range(1, 0));
            elem_bus.last_item  <= 1'($urandom_range(1, 0));
            @(negedge clk);
        end
        elem_bus.valid      <= 1'b1;
        elem_bus.value      <= v;
        elem_bus.is_present <= p;
        elem_bus.last_item  <= l;
        @(posedge clk);
        while (!elem_bus.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_column();
        if (column.size() == 0)
            add_elem(rand_value(), 1'b0);
        for (int i = 0; i < column.size(); i++)
            send_elem(column[i].value, column[i].present, i == column.size() - 1);
        column.delete();
    endtask

    // Few distinct values with skewed frequencies, so ties and repeat counts are common.
    task automatic build_pool_column();
        value_t      pool [8];
        int unsigned sz;
        int unsigned len;
        int unsigned null_pct;
        sz = $urandom_range(8, 1);
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(5, 0))
                0: pool[i] = '0;
                1: pool[i] = '1;
                2: pool[i] = (i == 0) ? rand_value()
                                      : pool[i-1] ^ (value_t'(1) << $urandom_range(63, 0));
                default: pool[i] = rand_value();
            endcase
        end
        len      = chance(10) ? $urandom_range(120, 41) : $urandom_range(40, 1);
        null_pct = chance(8) ? 100 : $urandom_range(30, 0);
        for (int i = 0; i < len; i++)
        begin
            add_elem(pool[$urandom_range($urandom_range(sz - 1, 0), 0)], !chance(null_pct));
        end
    endtask

    // Close to TABLE_DEPTH distinct values: sometimes too few to fill the table, sometimes enough to spill past it.
    task automatic build_overflow_column();
        int unsigned n;
        value_t      base;
        n    = $urandom_range(TABLE_DEPTH + 4, TABLE_DEPTH - 2);
        base = rand_value();
        for (int i = 0; i < n; i++)
        begin
            add_elem(base + value_t'(i), 1'b1);
            if (chance(20))
                add_elem(base + value_t'($urandom_range(i, 0)), 1'b1);
            if (chance(5))
                add_elem(base + value_t'($urandom_range(n + 3, 0)), 1'b0);
        end
        repeat ($urandom_range(15, 3))
            add_elem(base + value_t'($urandom_range(n + 2, 0)), !chance(10));
    endtask

    task automatic build_wide_column();
        repeat ($urandom_range(30, 1))
            add_elem(rand_value(), !chance(30));
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned stop_at;
        int unsigned sel;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            sel = $urandom_range(99, 0);
            if (sel < 12)
                build_overflow_column();
            else if (sel < 27)
                build_wide_column();
            else
                build_pool_column();
            send_column();
        end
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
            begin
                result_bus.ready <= 1'b0;
            end
            else if (hold_cycles != 0)
            begin
                result_bus.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                result_bus.ready <= !chance(recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((elem_bus.valid && elem_bus.ready) || (result_bus.valid && result_bus.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        elem_bus.valid      = 1'b0;
        elem_bus.value      = '0;
        elem_bus.is_present = 1'b0;
        elem_bus.last_item  = 1'b0;
        rst_n               = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Empty column and an all-null column.
        add_elem(rand_value(), 1'b0);
        send_column();
        add_elem('1, 1'b0);
        add_elem('0, 1'b0);
        send_column();
        // Single elements at both extremes of the value range.
        add_elem('0, 1'b1);
        send_column();
        add_elem('1, 1'b1);
        send_column();
        // Tie: the second value reaches two first and must keep the top spot.
        add_elem(64'h0123_4567_89AB_CDEF, 1'b1);
        add_elem(64'hFEDC_BA98_7654_3210, 1'b1);
        add_elem(64'hFEDC_BA98_7654_3210, 1'b1);
        add_elem(64'h0123_4567_89AB_CDEF, 1'b1);
        send_column();
        // Null last element still closes the column.
        add_elem(64'h0000_0000_DEAD_BEEF, 1'b1);
        add_elem(64'h0000_0000_DEAD_BEEF, 1'b1);
        add_elem(64'h5555_AAAA_5555_AAAA, 1'b1);
        add_elem(64'h0000_0000_DEAD_BEEF, 1'b0);
        send_column();
        // Values one bit apart must be told apart.
        add_elem(64'h8000_0000_0000_0000, 1'b1);
        add_elem(64'h0000_0000_0000_0000, 1'b1);
        add_elem(64'h0000_0000_0000_0001, 1'b1);
        add_elem(64'h0000_0000_0000_0000, 1'b1);
        send_column();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // The sender keeps offering while results back up behind the hold-off.
                    hold_cycles    = HOLD_OFF_CYCLES;
                end
                1:
                begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    // Let the block drain completely before going on.
                    elem_bus.valid <= 1'b0;
                    @(negedge clk);
                    while (pending_results != 0)
                        @(negedge clk);
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                end
                default:
                begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            run_random(PHASE_ITEMS);
        end

        elem_bus.valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 16) @(negedge clk);

        if (fail_count == 0 && pending_results == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
